### rtl/rfct_pkg.sv
package rfct_pkg;

    localparam int MAX_POSITIONS = 65536;
    localparam int POS_W         = 16;
    localparam int CNT_W         = 17;
    localparam int ADDR_W        = 17;
    localparam int NODE_DEPTH    = 131071;
    localparam int STACK_DEPTH   = 17;
    localparam int SP_W          = 5;

    localparam logic CMD_FLIP  = 1'b0;
    localparam logic CMD_COUNT = 1'b1;

    typedef struct packed {
        logic             lazy;
        logic [CNT_W-1:0] cnt;
    } node_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic              right;
        logic              cinv;
        logic [CNT_W-1:0]  lacc;
    } frame_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_RET,
        ST_DONE
    } state_t;

endpackage

### rtl/rfct_node_ram.sv
module rfct_node_ram (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        we,
    input  logic [rfct_pkg::ADDR_W-1:0] addr,
    input  rfct_pkg::node_t             wdata,
    output rfct_pkg::node_t             rdata
);

    rfct_pkg::node_t mem [rfct_pkg::NODE_DEPTH];
    rfct_pkg::node_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/range_flip_count_tree.sv
// Range flip / range count over a row of flags, kept as a lazy segment tree in one RAM.
// Input channel s_*: one item per command; cmd 0 inverts flags range_low..range_high,
// cmd 1 counts set flags there. The high end is clipped to coins_in_use-1.
// Result channel m_*: one item (set_count) per count command, none per flip.
// Config channel cfg_*: writes coins_in_use (0 acts as 1, above 65536 saturates);
// every write empties the tree and starts a clearing pass.
// Each visited node is read (ST_READ) and then evaluated (ST_EVAL), and each return
// to its parent passes through ST_RET; roughly 4 nodes per level are visited over
// up to 17 levels, and the walk is bound by the single-port node RAM.
// One item is in work at a time; s_tready is high only while idle and no config
// write is offered.
// Reset and each config write run a clearing pass over all 131071 nodes, one node
// per cycle, during which no item is taken.
// A finished count waits in the output register while the receiver stalls;
// the next item is taken once it has been loaded there.
module range_flip_count_tree (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd, range_low, range_high, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // set_count, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data   // coins_in_use
);

    localparam int PW = rfct_pkg::POS_W;
    localparam int CW = rfct_pkg::CNT_W;
    localparam int AW = rfct_pkg::ADDR_W;
    localparam int SW = rfct_pkg::SP_W;

    rfct_pkg::state_t state_reg, state_next;

    logic [AW-1:0] cur_idx_reg, cur_idx_next;
    logic [PW-1:0] cur_lo_reg, cur_lo_next;
    logic [PW-1:0] cur_hi_reg, cur_hi_next;
    logic          cur_inv_reg, cur_inv_next;
    logic          cmd_reg, cmd_next;
    logic [PW-1:0] a_reg, a_next;
    logic [PW-1:0] b_reg, b_next;
    logic [CW-1:0] ret_reg, ret_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [CW-1:0] len_reg, len_next;
    logic          m_valid_reg, m_valid_next;
    logic [CW-1:0] m_data_reg, m_data_next;

    rfct_pkg::frame_t stack_reg [rfct_pkg::STACK_DEPTH];
    rfct_pkg::frame_t push_frame, top_frame, top_upd;
    logic             push_en, upd_en;

    logic            ram_en, ram_we;
    logic [AW-1:0]   ram_addr;
    rfct_pkg::node_t ram_wdata, ram_rdata;

    logic          s_fire, cfg_fire, out_free;
    logic          in_cmd;
    logic [PW-1:0] in_lo, in_hi, in_hi_clip;
    logic [CW-1:0] last_pos, cfg_len;
    logic          in_empty;

    logic [CW-1:0] span, cnt_eff, cnt_flip, sum;
    logic          lz_eff, leaf, disj, full;
    logic [PW-1:0] mid;
    logic [AW-1:0] left_idx, right_idx;
    logic [SW-1:0] sp_m1;

    rfct_node_ram u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == rfct_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(24 - CW){1'b0}}, m_data_reg};

    assign s_fire   = s_tvalid && s_tready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !m_valid_reg || m_tready;

    assign in_cmd     = s_tdata[0];
    assign in_lo      = s_tdata[16:1];
    assign in_hi      = s_tdata[32:17];
    assign last_pos   = len_reg - 1'b1;
    assign in_hi_clip = ({1'b0, in_hi} > last_pos) ? last_pos[PW-1:0] : in_hi;
    assign in_empty   = in_lo > in_hi_clip;

    assign cfg_len = (cfg_data == '0) ? CW'(1) :
                     (cfg_data > CW'(rfct_pkg::MAX_POSITIONS)) ?
                     CW'(rfct_pkg::MAX_POSITIONS) : cfg_data;

    assign span      = {1'b0, cur_hi_reg} - {1'b0, cur_lo_reg} + 1'b1;
    assign cnt_eff   = cur_inv_reg ? (span - ram_rdata.cnt) : ram_rdata.cnt;
    assign cnt_flip  = span - cnt_eff;
    assign lz_eff    = ram_rdata.lazy ^ cur_inv_reg;
    assign leaf      = (cur_lo_reg == cur_hi_reg);
    assign disj      = (a_reg > cur_hi_reg) || (b_reg < cur_lo_reg);
    assign full      = (a_reg <= cur_lo_reg) && (cur_hi_reg <= b_reg);
    assign mid       = cur_lo_reg + ((cur_hi_reg - cur_lo_reg) >> 1);
    assign left_idx  = {cur_idx_reg[AW-2:0], 1'b0} + AW'(1);
    assign right_idx = {top_frame.idx[AW-2:0], 1'b0} + AW'(2);

    assign sp_m1     = sp_reg - 1'b1;
    assign top_frame = stack_reg[sp_m1];
    assign sum       = top_frame.lacc + ret_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rfct_pkg::ST_CLEAR: begin
                if (clr_reg == AW'(rfct_pkg::NODE_DEPTH - 1)) state_next = rfct_pkg::ST_IDLE;
            end
            rfct_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (!in_empty) state_next = rfct_pkg::ST_READ;
                    else if (in_cmd == rfct_pkg::CMD_COUNT) state_next = rfct_pkg::ST_DONE;
                end
            end
            rfct_pkg::ST_READ: state_next = rfct_pkg::ST_EVAL;
            rfct_pkg::ST_EVAL: begin
                if (disj || full) state_next = rfct_pkg::ST_RET;
                else state_next = rfct_pkg::ST_READ;
            end
            rfct_pkg::ST_RET: begin
                if (sp_reg == '0) begin
                    state_next = (cmd_reg == rfct_pkg::CMD_COUNT) ? rfct_pkg::ST_DONE
                                                                 : rfct_pkg::ST_IDLE;
                end else if (!top_frame.right) begin
                    state_next = rfct_pkg::ST_READ;
                end
            end
            rfct_pkg::ST_DONE: begin
                if (out_free) state_next = rfct_pkg::ST_IDLE;
            end
            default: state_next = rfct_pkg::ST_CLEAR;
        endcase
        if (cfg_fire) state_next = rfct_pkg::ST_CLEAR;
    end

    always_comb begin
        cur_idx_next = cur_idx_reg;
        cur_lo_next  = cur_lo_reg;
        cur_hi_next  = cur_hi_reg;
        cur_inv_next = cur_inv_reg;
        cmd_next     = cmd_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        ret_next     = ret_reg;
        sp_next      = sp_reg;
        clr_next     = clr_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        push_en      = 1'b0;
        push_frame   = '0;
        upd_en       = 1'b0;
        top_upd      = top_frame;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = cur_idx_reg;
        ram_wdata    = '0;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            rfct_pkg::ST_CLEAR: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            rfct_pkg::ST_IDLE: begin
                if (s_fire) begin
                    cmd_next     = in_cmd;
                    a_next       = in_lo;
                    b_next       = in_hi_clip;
                    ret_next     = '0;
                    sp_next      = '0;
                    cur_idx_next = '0;
                    cur_lo_next  = '0;
                    cur_hi_next  = last_pos[PW-1:0];
                    cur_inv_next = 1'b0;
                end
            end
            rfct_pkg::ST_READ: begin
                ram_en = 1'b1;
            end
            rfct_pkg::ST_EVAL: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                if (disj) begin
                    ram_wdata = '{lazy: lz_eff, cnt: cnt_eff};
                    ret_next  = (cmd_reg == rfct_pkg::CMD_FLIP) ? cnt_eff : '0;
                end else if (full) begin
                    if (cmd_reg == rfct_pkg::CMD_FLIP) begin
                        ram_wdata = '{lazy: lz_eff ^ !leaf, cnt: cnt_flip};
                        ret_next  = cnt_flip;
                    end else begin
                        ram_wdata = '{lazy: lz_eff, cnt: cnt_eff};
                        ret_next  = cnt_eff;
                    end
                end else begin
                    ram_wdata  = '{lazy: 1'b0, cnt: cnt_eff};
                    push_en    = 1'b1;
                    push_frame = '{idx: cur_idx_reg, lo: cur_lo_reg, hi: cur_hi_reg,
                                   right: 1'b0, cinv: lz_eff, lacc: '0};
                    sp_next      = sp_reg + 1'b1;
                    cur_idx_next = left_idx;
                    cur_hi_next  = mid;
                    cur_inv_next = lz_eff;
                end
            end
            rfct_pkg::ST_RET: begin
                if (sp_reg != '0) begin
                    if (!top_frame.right) begin
                        upd_en        = 1'b1;
                        top_upd.right = 1'b1;
                        top_upd.lacc  = ret_reg;
                        cur_idx_next  = right_idx;
                        cur_lo_next   = top_frame.lo + ((top_frame.hi - top_frame.lo) >> 1)
                                        + 1'b1;
                        cur_hi_next   = top_frame.hi;
                        cur_inv_next  = top_frame.cinv;
                    end else begin
                        ret_next = sum;
                        sp_next  = sp_m1;
                        if (cmd_reg == rfct_pkg::CMD_FLIP) begin
                            ram_en    = 1'b1;
                            ram_we    = 1'b1;
                            ram_addr  = top_frame.idx;
                            ram_wdata = '{lazy: 1'b0, cnt: sum};
                        end
                    end
                end
            end
            rfct_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = ret_reg;
                end
            end
            default: ;
        endcase

        if (cfg_fire) begin
            len_next = cfg_len;
            clr_next = '0;
            sp_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rfct_pkg::ST_CLEAR;
            clr_reg     <= '0;
            sp_reg      <= '0;
            len_reg     <= CW'(rfct_pkg::MAX_POSITIONS);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_idx_reg <= cur_idx_next;
        cur_lo_reg  <= cur_lo_next;
        cur_hi_reg  <= cur_hi_next;
        cur_inv_reg <= cur_inv_next;
        cmd_reg     <= cmd_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        ret_reg     <= ret_next;
        m_data_reg  <= m_data_next;
        if (push_en) stack_reg[sp_reg] <= push_frame;
        if (upd_en) stack_reg[sp_m1] <= top_upd;
    end

`ifndef ASSERT_OFF
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SW'(rfct_pkg::STACK_DEPTH))
        else $error("stack overflow");

    a_no_take_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rfct_pkg::ST_CLEAR) |-> !s_tready)
        else $error("item taken during clearing");

    a_done_empty_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rfct_pkg::ST_DONE) |-> (sp_reg == '0))
        else $error("result while tree walk open");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("result dropped under stall");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef logic [rfct_pkg::POS_W-1:0] pos_t;

    typedef struct packed {
        logic cmd;
        pos_t lo;
        pos_t hi;
    } command_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // cmd, range_low, range_high, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // set_count, zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;  // coins_in_use

    range_flip_count_tree dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    bit       flags [rfct_pkg::MAX_POSITIONS];
    int       row_len;
    command_t pending_cmds[$];
    int       expected_counts[$];
    command_t in_flight;
    int       mismatches = 0;
    int       cyc;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic bit calm();
        return (cyc % 5000) < 1200;
    endfunction

    function automatic void set_length(logic [16:0] v);
        row_len = (v == 0) ? 1 :
                  ((v > rfct_pkg::MAX_POSITIONS) ? rfct_pkg::MAX_POSITIONS : int'(v));
        foreach (flags[i]) flags[i] = 1'b0;
    endfunction

    function automatic void apply_command(command_t c);
        int a;
        int b;
        int total;
        a = int'(c.lo);
        b = (int'(c.hi) > row_len - 1) ? row_len - 1 : int'(c.hi);
        total = 0;
        for (int i = a; i <= b; i++) begin
            if (c.cmd == rfct_pkg::CMD_FLIP) flags[i] = ~flags[i];
            else total += int'(flags[i]);
        end
        if (c.cmd == rfct_pkg::CMD_COUNT) expected_counts.push_back(total);
    endfunction

    function automatic command_t random_command();
        command_t c;
        int span;
        pos_t t;
        c.cmd = ($urandom_range(0, 1) != 0);
        span = (row_len + 2 > 65536) ? 65536 : row_len + 2;
        if ($urandom_range(0, 9) == 0) begin
            c.lo = pos_t'($urandom);
            c.hi = pos_t'($urandom);
        end else begin
            c.lo = pos_t'($urandom_range(0, span - 1));
            c.hi = pos_t'($urandom_range(0, span - 1));
            if (c.lo > c.hi && $urandom_range(0, 9) < 8) begin
                t = c.lo;
                c.lo = c.hi;
                c.hi = t;
            end
        end
        return c;
    endfunction

    function automatic command_t mk(logic cmd, int lo, int hi);
        command_t c;
        c.cmd = cmd;
        c.lo = pos_t'(lo);
        c.hi = pos_t'(hi);
        return c;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            cyc <= 0;
        end else begin
            cyc <= cyc + 1;
            if (s_tvalid && s_tready) apply_command(in_flight);
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && (calm() || $urandom_range(0, 99) >= 14)) begin
                    in_flight = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, in_flight.hi, in_flight.lo, in_flight.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_counts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected count item: set_count=%0d", m_tdata[16:0]);
                end else if (m_tdata[16:0] !== expected_counts[0][16:0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("set_count: expected %0d, actual %0d",
                                 expected_counts[0], m_tdata[16:0]);
                    void'(expected_counts.pop_front());
                end else begin
                    void'(expected_counts.pop_front());
                end
            end
            m_tready <= calm() || ($urandom_range(0, 99) >= 14);
        end
    end

    task automatic drain();
        while (pending_cmds.size() != 0 || s_tvalid || expected_counts.size() != 0)
            @(posedge aclk);
        repeat (1000) @(posedge aclk);
    endtask

    task automatic write_length(logic [16:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        set_length(v);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) pending_cmds.push_back(random_command());
        drain();
    endtask

    initial begin
        logic [16:0] lengths[4];
        cfg_valid = 1'b0;
        cfg_data  = '0;
        set_length(17'd65536);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 0, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_FLIP, 0, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 0, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 0, 0));
        pending_cmds.push_back(mk(rfct_pkg::CMD_FLIP, 5, 3));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 3, 5));
        pending_cmds.push_back(mk(rfct_pkg::CMD_FLIP, 65535, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 65535, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 65534, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_FLIP, 100, 200));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 150, 250));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 10, 9));
        pending_cmds.push_back(mk(rfct_pkg::CMD_FLIP, 21845, 43690));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 0, 32767));
        drain();
        random_phase(200);

        write_length(17'd0);
        pending_cmds.push_back(mk(rfct_pkg::CMD_FLIP, 0, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 0, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 1, 65535));
        pending_cmds.push_back(mk(rfct_pkg::CMD_FLIP, 0, 0));
        pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 0, 0));
        drain();
        random_phase(60);

        lengths[0] = 17'd131071;
        lengths[1] = 17'd23;
        lengths[2] = 17'd1000 + 17'($urandom_range(0, 3000));
        lengths[3] = 17'd65536;
        foreach (lengths[k]) begin
            write_length(lengths[k]);
            pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 0, 65535));
            pending_cmds.push_back(mk(rfct_pkg::CMD_FLIP, 0, 65535));
            pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 0, 65535));
            pending_cmds.push_back(mk(rfct_pkg::CMD_COUNT, 65535, 65535));
            random_phase(k == 1 || k == 2 ? 350 : 120);
        end

        if (mismatches == 0 && expected_counts.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### range_flip_count_tree.f
rtl/rfct_pkg.sv
rtl/rfct_node_ram.sv
rtl/range_flip_count_tree.sv
test/tb_top.sv
